// File: sv/cmdf_pkg.sv
// ----------------------------------------------------------------------------
// cmdf_pkg
// Shared types and codes for the cluster message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdf_pkg;

  // Field kind codes carried on the result word
  localparam logic [3:0] KIND_TYPE     = 4'd0;
  localparam logic [3:0] KIND_NODELEN  = 4'd1;
  localparam logic [3:0] KIND_NODECHAR = 4'd2;
  localparam logic [3:0] KIND_NAMELEN  = 4'd3;
  localparam logic [3:0] KIND_NAMECHAR = 4'd4;
  localparam logic [3:0] KIND_ADDRESS  = 4'd5;
  localparam logic [3:0] KIND_SESSION  = 4'd6;
  localparam logic [3:0] KIND_PAYLOAD  = 4'd7;
  localparam logic [3:0] KIND_OKFLAG   = 4'd8;
  localparam logic [3:0] KIND_TRACE    = 4'd9;
  localparam logic [3:0] KIND_END      = 4'd10;

  // End-of-message status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TRUNC     = 2'd1;
  localparam logic [1:0] STAT_BAD_TYPE  = 2'd2;
  localparam logic [1:0] STAT_BAD_RESULT = 2'd3;

  // Message type codes
  localparam logic [1:0] MSG_REQ_ADDR = 2'd0;
  localparam logic [1:0] MSG_REQ_NAME = 2'd1;
  localparam logic [1:0] MSG_TRACE    = 2'd2;
  localparam logic [1:0] MSG_RESPONSE = 2'd3;

  // Output queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        is_resp;
    logic        push;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Up to two result words per input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

`default_nettype wire

// File: sv/cmdf_parser.sv
// ----------------------------------------------------------------------------
// cmdf_parser
// Message state machine: one body byte in, up to two result words out.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdf_parser
  import cmdf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic         fin_i,
  output result_pair_t      res_o
);

  localparam logic [3:0] PH_TYPE    = 4'd0;
  localparam logic [3:0] PH_NODELEN = 4'd1;
  localparam logic [3:0] PH_NODE    = 4'd2;
  localparam logic [3:0] PH_ADDR    = 4'd3;
  localparam logic [3:0] PH_NAMELEN = 4'd4;
  localparam logic [3:0] PH_NAME    = 4'd5;
  localparam logic [3:0] PH_SESSION = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_TRACE   = 4'd8;
  localparam logic [3:0] PH_RESULT  = 4'd9;
  localparam logic [3:0] PH_DRAIN   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  left_q, left_d;
  logic [23:0] word_q, word_d;   // top byte lands straight in the output
  logic [1:0]  idx_q, idx_d;
  logic        sz_q, sz_d;
  logic [1:0]  err_q, err_d;

  logic        have;
  logic [3:0]  fkind;
  logic [31:0] fval;
  logic [31:0] word_ext;
  logic        word_done;
  logic [7:0]  left_dec;
  logic [3:0]  after_node;
  logic        resp;
  logic [1:0]  status;
  logic        push;
  result_t     field_r, end_r;

  assign word_ext  = {8'h00, word_q} | ({24'h000000, byte_i} << {idx_q, 3'b000});
  assign word_done = (idx_q == 2'd3);
  assign left_dec  = left_q - 8'd1;
  assign after_node = (kind_q == MSG_REQ_ADDR) ? PH_ADDR : PH_NAMELEN;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    left_d  = left_q;
    word_d  = word_q;
    idx_d   = idx_q;
    sz_d    = sz_q;
    err_d   = err_q;
    have    = 1'b0;
    fkind   = KIND_TYPE;
    fval    = {24'h000000, byte_i};

    case (phase_q)
      PH_TYPE: begin
        have  = 1'b1;
        fkind = KIND_TYPE;
        if (byte_i > 8'd3) begin
          err_d   = STAT_BAD_TYPE;
          phase_d = PH_DRAIN;
        end else begin
          kind_d = byte_i[1:0];
          case (byte_i[1:0])
            MSG_REQ_ADDR, MSG_REQ_NAME: phase_d = PH_NODELEN;
            MSG_TRACE:                  phase_d = PH_TRACE;
            default:                    phase_d = PH_SESSION;
          endcase
        end
      end
      PH_NODELEN: begin
        have    = 1'b1;
        fkind   = KIND_NODELEN;
        left_d  = byte_i;
        phase_d = (byte_i == 8'd0) ? after_node : PH_NODE;
      end
      PH_NODE: begin
        have   = 1'b1;
        fkind  = KIND_NODECHAR;
        left_d = left_dec;
        if (left_dec == 8'd0) phase_d = after_node;
      end
      PH_ADDR, PH_SESSION: begin
        if (word_done) begin
          have   = 1'b1;
          fval   = word_ext;
          word_d = '0;
          idx_d  = 2'd0;
          if (phase_q == PH_ADDR) begin
            fkind   = KIND_ADDRESS;
            phase_d = PH_SESSION;
          end else begin
            fkind   = KIND_SESSION;
            sz_d    = (word_ext == 32'd0);
            phase_d = (kind_q == MSG_RESPONSE) ? PH_RESULT : PH_PAYLOAD;
          end
        end else begin
          word_d = word_ext[23:0];
          idx_d  = idx_q + 2'd1;
        end
      end
      PH_NAMELEN: begin
        have    = 1'b1;
        fkind   = KIND_NAMELEN;
        left_d  = byte_i;
        phase_d = (byte_i == 8'd0) ? PH_SESSION : PH_NAME;
      end
      PH_NAME: begin
        have   = 1'b1;
        fkind  = KIND_NAMECHAR;
        left_d = left_dec;
        if (left_dec == 8'd0) phase_d = PH_SESSION;
      end
      PH_PAYLOAD: begin
        have  = 1'b1;
        fkind = KIND_PAYLOAD;
      end
      PH_TRACE: begin
        have  = 1'b1;
        fkind = KIND_TRACE;
      end
      PH_RESULT: begin
        have  = 1'b1;
        fkind = KIND_OKFLAG;
        if (byte_i > 8'd1) begin
          err_d   = STAT_BAD_RESULT;
          phase_d = PH_DRAIN;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      default: phase_d = PH_DRAIN;
    endcase
  end

  // End word: status and push come from the post-step state
  always_comb begin
    resp = (err_d != STAT_BAD_TYPE) && (kind_d == MSG_RESPONSE);
    if (err_d != STAT_OK) begin
      status = err_d;
    end else if (phase_d == PH_PAYLOAD || phase_d == PH_TRACE) begin
      status = STAT_OK;
    end else begin
      status = STAT_TRUNC;
    end
    push = (status == STAT_OK) && !kind_d[1] && (phase_d == PH_PAYLOAD) && sz_d;

    field_r = '{kind: fkind, value: fval, is_resp: resp, push: 1'b0,
                status: STAT_OK, last: 1'b0};
    end_r   = '{kind: KIND_END, value: 32'd0, is_resp: resp, push: push,
                status: status, last: 1'b1};

    res_o.count = {1'b0, have} + {1'b0, fin_i};
    res_o.r0    = have ? field_r : end_r;
    res_o.r1    = end_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= 2'd0;
      left_q  <= 8'd0;
      word_q  <= '0;
      idx_q   <= 2'd0;
      sz_q    <= 1'b0;
      err_q   <= STAT_OK;
    end else if (step_i) begin
      if (fin_i) begin
        phase_q <= PH_TYPE;
        kind_q  <= 2'd0;
        left_q  <= 8'd0;
        word_q  <= '0;
        idx_q   <= 2'd0;
        sz_q    <= 1'b0;
        err_q   <= STAT_OK;
      end else begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        left_q  <= left_d;
        word_q  <= word_d;
        idx_q   <= idx_d;
        sz_q    <= sz_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cmdf_out_queue.sv
// ----------------------------------------------------------------------------
// cmdf_out_queue
// Small result queue: takes up to two words per cycle, hands out one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdf_out_queue
  import cmdf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire result_pair_t pair_i,
  output logic              room_o,   // space for two words
  output logic              valid_o,
  input  wire logic         ready_i,
  output result_t           head_o
);

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic [QPtrW-1:0]  wr_nxt;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push  = push_i ? pair_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = wr_q + QPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q]   <= pair_i.r0;
    if (n_push == 2'd2) mem_q[wr_nxt] <= pair_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(n_push);
      if (pop) rd_q <= rd_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(n_push) - QCntW'(pop);
    end
  end

endmodule

`default_nettype wire

// File: sv/cluster_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// cluster_message_deframer_unit
// Byte-wide deframer for cluster messages: emits header fields, payload
// bytes and an end word with status for every message.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then parsed once the
//   result queue has room, and its result words are written into the queue,
//   whose head drives the output.
// Throughput: one byte per cycle; a final byte adds an end word, so output
//   runs at one word per cycle while out_ready_i is high, and the input stalls
//   while the queue has fewer than two free slots.
// Reset: rst_ni clears the parser to "expect type byte" and empties the queue.
`default_nettype none

module cluster_message_deframer_unit
  import cmdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       field_kind_o,
  output logic [31:0]      field_value_o,
  output logic             is_response_o,
  output logic             push_flag_o,
  output logic [1:0]       status_o,
  output logic             last_of_message_o
);

  // Input register
  logic         in_vld_q;
  logic [7:0]   byte_q;
  logic         fin_q;

  logic         room;
  logic         step;
  logic         load;
  result_pair_t pair;
  result_t      head;

  // The registered byte is parsed once the queue has room for two words.
  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  cmdf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .fin_i  (fin_q),
    .res_o  (pair)
  );

  cmdf_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign field_kind_o      = head.kind;
  assign field_value_o     = head.value;
  assign is_response_o     = head.is_resp;
  assign push_flag_o       = head.push;
  assign status_o          = head.status;
  assign last_of_message_o = head.last;

endmodule

`default_nettype wire
